### rtl/avr_dec_pkg.sv
// ---------------------------------------------------------------------------
// avr_dec_pkg
// Types and class codes shared by the AVR instruction decoder.
// ---------------------------------------------------------------------------
package avr_dec_pkg;

    localparam int FIELD_ADDR_W = 22;

    typedef enum logic [6:0] {
        C_COM, C_NEG, C_SWAP, C_INC, C_ASR, C_LSR, C_ROR, C_IJMP, C_EIJMP, C_RET,
        C_ICALL, C_RETI, C_EICALL, C_CLC, C_CLZ, C_CLN, C_CLV, C_CLS, C_CLH, C_CLT,
        C_CLI, C_SEC, C_SEZ, C_SEN, C_SEV, C_SES, C_SEH, C_SET, C_SEI, C_DEC,
        C_CALL, C_JMP, C_NOP, C_MOVW, C_MULS, C_MULSU, C_FMUL, C_FMULS, C_FMULSU, C_CP,
        C_CPC, C_SBC, C_ADD, C_CPSE, C_SUB, C_ADC, C_AND, C_EOR, C_OR, C_MOV,
        C_MUL, C_OUT, C_IN, C_CBI, C_SBIC, C_SBI, C_SBIS, C_LD, C_ST, C_LDI,
        C_LDD, C_STD, C_PUSH, C_LPM, C_ELPM, C_POP, C_BLD, C_BST, C_SBRC, C_SBRS,
        C_BRCC, C_BRNE, C_BRPL, C_BRVC, C_BRGE, C_BRHC, C_BRID, C_BRCS, C_BREQ, C_BRMI,
        C_BRVS, C_BRLT, C_BRHS, C_BRIE, C_SLEEP, C_BREAK, C_WDR, C_BRTC, C_BRTS
    } cls_t;

    // pointer modes and pointer registers
    localparam logic [1:0] PM_PLAIN = 2'd0;
    localparam logic [1:0] PM_INC   = 2'd1;
    localparam logic [1:0] PM_DEC   = 2'd2;
    localparam logic [2:0] PR_NONE  = 3'd0;
    localparam logic [2:0] PR_X     = 3'd1;
    localparam logic [2:0] PR_Y     = 3'd2;
    localparam logic [2:0] PR_Z     = 3'd3;
    localparam logic [2:0] PR_W     = 3'd4;

    // target computation selects
    typedef enum logic [1:0] {
        TG_NONE, TG_ABS, TG_SKIP, TG_REL
    } tsel_t;

    typedef struct packed {
        logic [21:0] word_addr;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } in_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [6:0]  instr_class;
        logic [1:0]  ptr_mode;
        logic [1:0]  size_words;
        logic [4:0]  reg_first;
        logic [4:0]  reg_second;
        logic [2:0]  ptr_reg;
        logic [7:0]  immediate;
        logic [2:0]  bit_index;
        logic [21:0] target_addr;
        logic [21:0] next_addr;
    } out_item_t;

    // decoded fields before address arithmetic
    typedef struct packed {
        logic        ok;
        logic [6:0]  cls;
        logic [1:0]  mode;
        logic [1:0]  size;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [2:0]  preg;
        logic [7:0]  imm;
        logic [2:0]  bitn;
        tsel_t       tsel;
        logic [21:0] tabs;   // absolute target, skip length or signed offset (sign extended)
    } dec_t;

    function automatic logic [1:0] word_len(input logic [15:0] w);
        if ((w & 16'hFE0C) == 16'h940C || (w & 16'hFC0F) == 16'h9000)
            return 2'd2;
        return 2'd1;
    endfunction

    function automatic dec_t decode(input logic [15:0] w, input logic [15:0] w2);
        dec_t d;
        logic [4:0] rd5;
        logic [4:0] rd4;
        logic [7:0] k8;
        logic [3:0] lo;
        logic [2:0] s;
        logic [3:0] op;
        logic [1:0] k;
        logic [1:0] sel;
        logic [11:0] off;
        logic [6:0] kb;
        rd5 = w[8:4];
        rd4 = {1'b1, w[7:4]};
        k8 = {w[11:8], w[3:0]};
        lo = w[3:0];
        s = w[6:4];
        op = w[13:10];
        k = w[5:4];
        sel = w[9:8];
        off = w[11:0];
        kb = w[9:3];
        d = '0;
        d.size = 2'd1;
        d.tsel = TG_NONE;
        d.ok = 1'b1;
        if ((w & 16'hFE00) == 16'h9400) begin
            if (lo >= 4'hC) begin
                d.cls = w[1] ? C_CALL : C_JMP;
                d.size = 2'd2;
                d.tsel = TG_ABS;
                d.tabs = {w[8:4], w[0], w2};
            end else if (lo == 4'h8 || lo == 4'h9) begin
                case (w)
                    16'h9409: d.cls = C_IJMP;
                    16'h9419: d.cls = C_EIJMP;
                    16'h9508: d.cls = C_RET;
                    16'h9509: d.cls = C_ICALL;
                    16'h9518: d.cls = C_RETI;
                    16'h9519: d.cls = C_EICALL;
                    16'h9588: d.cls = C_SLEEP;
                    16'h9598: d.cls = C_BREAK;
                    16'h95A8: d.cls = C_WDR;
                    16'h95C8: begin d.cls = C_LPM; d.preg = PR_Z; end
                    default:
                    begin
                        if ((w & 16'hFF0F) == 16'h9408) begin
                            d.cls = w[7] ? 7'(C_CLC + s) : 7'(C_SEC + s);
                            d.bitn = s;
                        end else
                            d.ok = 1'b0;
                    end
                endcase
            end else begin
                d.ra = rd5;
                case (lo)
                    4'h0: d.cls = C_COM;
                    4'h1: d.cls = C_NEG;
                    4'h2: d.cls = C_SWAP;
                    4'h3: d.cls = C_INC;
                    4'h5: d.cls = C_ASR;
                    4'h6: d.cls = C_LSR;
                    4'h7: d.cls = C_ROR;
                    4'hA: d.cls = C_DEC;
                    default: d.ok = 1'b0;
                endcase
            end
        end else if (w[15:14] == 2'b00) begin
            if (w[13:10] == 4'd0) begin
                case (sel)
                    2'd0: d.ok = (w == 16'h0000);
                    2'd1:
                    begin
                        d.cls = C_MOVW; d.ra = {w[7:4], 1'b0}; d.rb = {w[3:0], 1'b0};
                    end
                    2'd2:
                    begin
                        d.cls = C_MULS; d.ra = rd4; d.rb = {1'b1, w[3:0]};
                    end
                    default:
                    begin
                        case ({w[7], w[3]})
                            2'b00: d.cls = C_MULSU;
                            2'b01: d.cls = C_FMUL;
                            2'b10: d.cls = C_FMULS;
                            default: d.cls = C_FMULSU;
                        endcase
                        d.ra = {2'b10, w[6:4]};
                        d.rb = {2'b10, w[2:0]};
                    end
                endcase
                if (sel == 2'd0) d.cls = C_NOP;
            end else if (w[13:12] == 2'b11) begin
                d.cls = C_CP; d.ra = rd4; d.imm = k8;
            end else if (op > 4'd11) begin
                d.ok = 1'b0;
            end else begin
                case (op)
                    4'd1: d.cls = C_CPC;
                    4'd2: d.cls = C_SBC;
                    4'd3: d.cls = C_ADD;
                    4'd4: d.cls = C_CPSE;
                    4'd5: d.cls = C_CP;
                    4'd6: d.cls = C_SUB;
                    4'd7: d.cls = C_ADC;
                    4'd8: d.cls = C_AND;
                    4'd9: d.cls = C_EOR;
                    4'd10: d.cls = C_OR;
                    default: d.cls = C_MOV;
                endcase
                d.ra = rd5;
                d.rb = {w[9], w[3:0]};
            end
        end else if ((w & 16'hFC00) == 16'h9C00) begin
            d.cls = C_MUL; d.ra = rd5; d.rb = {w[9], w[3:0]};
        end else if (w[15:12] == 4'hB) begin
            d.cls = w[11] ? C_OUT : C_IN;
            d.ra = rd5;
            d.imm = {2'b00, w[10:9], w[3:0]};
        end else if ((w & 16'hFC00) == 16'h9800) begin
            case (sel)
                2'd0: d.cls = C_CBI;
                2'd1: d.cls = C_SBIC;
                2'd2: d.cls = C_SBI;
                default: d.cls = C_SBIS;
            endcase
            d.bitn = w[2:0];
            d.imm = {3'b000, w[7:3]};
            if (sel[0]) begin
                d.tsel = TG_SKIP;
                d.tabs = 22'(word_len(w2));
            end
        end else if ((w & 16'hFC0F) == 16'h9000) begin
            d.cls = w[9] ? C_ST : C_LD;
            d.ra = rd5; d.size = 2'd2;
            d.tsel = TG_ABS;
            d.tabs = {6'd0, w2};
        end else if (w[15:12] == 4'hE) begin
            d.cls = C_LDI; d.ra = rd4; d.imm = k8;
        end else if (w[15:14] == 2'b01) begin
            case (w[13:12])
                2'd0: d.cls = C_SBC;
                2'd1: d.cls = C_SUB;
                2'd2: d.cls = C_OR;
                default: d.cls = C_AND;
            endcase
            d.ra = rd4; d.imm = k8;
        end else if ((w & 16'hFE00) == 16'h9600) begin
            d.cls = w[8] ? C_SUB : C_ADD;
            d.preg = (k != 2'd0) ? {1'b0, k} : PR_W;
            d.ra = {2'b11, k, 1'b0};
            d.imm = {2'b00, w[7:6], w[3:0]};
        end else if ((w & 16'hD000) == 16'h8000) begin
            d.cls = w[9] ? C_STD : C_LDD;
            d.ra = rd5;
            d.preg = w[3] ? PR_Y : PR_Z;
            d.imm = {2'b00, w[13], w[11:10], w[2:0]};
        end else if ((w & 16'hFC00) == 16'h9000) begin
            d.ra = rd5;
            d.cls = w[9] ? C_ST : C_LD;
            case (lo)
                4'h1: begin d.preg = PR_Z; d.mode = PM_INC; end
                4'h2: begin d.preg = PR_Z; d.mode = PM_DEC; end
                4'h9: begin d.preg = PR_Y; d.mode = PM_INC; end
                4'hA: begin d.preg = PR_Y; d.mode = PM_DEC; end
                4'hC: d.preg = PR_X;
                4'hD: begin d.preg = PR_X; d.mode = PM_INC; end
                4'hE: begin d.preg = PR_X; d.mode = PM_DEC; end
                4'hF: d.cls = w[9] ? C_PUSH : C_POP;
                4'h4, 4'h5, 4'h6, 4'h7:
                begin
                    if (w[9])
                        d.ok = 1'b0;
                    d.cls = lo[1] ? C_ELPM : C_LPM;
                    d.preg = PR_Z;
                    d.mode = {1'b0, lo[0]};
                end
                default: d.ok = 1'b0;
            endcase
        end else if ((w & 16'hF808) == 16'hF800) begin
            case (w[10:9])
                2'd0: d.cls = C_BLD;
                2'd1: d.cls = C_BST;
                2'd2: d.cls = C_SBRC;
                default: d.cls = C_SBRS;
            endcase
            d.ra = rd5;
            d.bitn = w[2:0];
            if (w[10]) begin
                d.tsel = TG_SKIP;
                d.tabs = 22'(word_len(w2));
            end
        end else if (w[15:13] == 3'b110) begin
            d.cls = w[12] ? C_CALL : C_JMP;
            d.tsel = TG_REL;
            d.tabs = {{10{off[11]}}, off};
        end else if (w[15:11] == 5'b11110) begin
            d.bitn = w[2:0];
            case ({w[10], w[2:0]})
                4'b0000: d.cls = C_BRCS;
                4'b0001: d.cls = C_BREQ;
                4'b0010: d.cls = C_BRMI;
                4'b0011: d.cls = C_BRVS;
                4'b0100: d.cls = C_BRLT;
                4'b0101: d.cls = C_BRHS;
                4'b0110: d.cls = C_BRTS;
                4'b0111: d.cls = C_BRIE;
                4'b1000: d.cls = C_BRCC;
                4'b1001: d.cls = C_BRNE;
                4'b1010: d.cls = C_BRPL;
                4'b1011: d.cls = C_BRVC;
                4'b1100: d.cls = C_BRGE;
                4'b1101: d.cls = C_BRHC;
                4'b1110: d.cls = C_BRTC;
                default: d.cls = C_BRID;
            endcase
            d.tsel = TG_REL;
            d.tabs = {{15{kb[6]}}, kb};
        end else begin
            d.ok = 1'b0;
        end
        if (!d.ok) begin
            d = '0;
            d.size = 2'd1;
            d.tsel = TG_NONE;
        end
        return d;
    endfunction

endpackage

### rtl/avr_instruction_decoder.sv
// Stages: input capture, decode, address add into the output register.
// Throughput: one item per cycle while the output is not stalled; set by the three-stage decode pipeline.
// A stall at the output holds each full stage, while empty stages still fill; no item is lost or repeated.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload is not reset.
// ---------------------------------------------------------------------------
// avr_instruction_decoder
// Pipelined AVR program word decoder: class, operands, targets.
// ---------------------------------------------------------------------------
module avr_instruction_decoder
    import avr_dec_pkg::*;
#(
    parameter int ADDR_BITS = 22
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam logic [FIELD_ADDR_W-1:0] ADDR_MASK =
        FIELD_ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // stage 1: captured input
    logic                    s1_vld_reg;
    in_item_t                s1_reg;
    // stage 2: decoded fields
    logic                    s2_vld_reg;
    dec_t                    s2_dec_reg;
    logic [FIELD_ADDR_W-1:0] s2_pc_reg;
    // stage 3: output
    logic                    s3_vld_reg;
    out_item_t               s3_reg;

    logic adv3, adv2, adv1;
    dec_t dec_next;
    logic [FIELD_ADDR_W-1:0] tgt_next;
    logic [FIELD_ADDR_W-1:0] nxt_next;
    out_item_t s3_next;

    assign adv3 = !s3_vld_reg || out_ready;
    assign adv2 = !s2_vld_reg || adv3;
    assign adv1 = !s1_vld_reg || adv2;
    assign in_ready = adv1;

    assign dec_next = decode(s1_reg.first_word, s1_reg.second_word);

    always_comb
    begin
        case (s2_dec_reg.tsel)
            TG_ABS:  tgt_next = s2_dec_reg.tabs;
            TG_SKIP: tgt_next = s2_pc_reg + 22'd1 + s2_dec_reg.tabs;
            TG_REL:  tgt_next = s2_pc_reg + 22'd1 + s2_dec_reg.tabs;
            default: tgt_next = '0;
        endcase
        nxt_next = s2_pc_reg + {20'd0, s2_dec_reg.size};
        s3_next.valid_res   = s2_dec_reg.ok;
        s3_next.instr_class = s2_dec_reg.cls;
        s3_next.ptr_mode    = s2_dec_reg.mode;
        s3_next.size_words  = s2_dec_reg.size;
        s3_next.reg_first   = s2_dec_reg.ra;
        s3_next.reg_second  = s2_dec_reg.rb;
        s3_next.ptr_reg     = s2_dec_reg.preg;
        s3_next.immediate   = s2_dec_reg.imm;
        s3_next.bit_index   = s2_dec_reg.bitn;
        s3_next.target_addr = tgt_next & ADDR_MASK;
        s3_next.next_addr   = nxt_next & ADDR_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_vld_reg <= in_valid;
            if (adv2) s2_vld_reg <= s1_vld_reg;
            if (adv3) s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_reg <= in_data;
        end
        if (adv2 && s1_vld_reg)
        begin
            s2_dec_reg <= dec_next;
            s2_pc_reg  <= s1_reg.word_addr & ADDR_MASK;
        end
        if (adv3 && s2_vld_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_vld_reg;
    assign out_data  = s3_reg;

endmodule

### rtl/avr_dec_checker.sv
// ---------------------------------------------------------------------------
// avr_dec_checker
// Port-level checks on the decoder's output channel and result fields.
// ---------------------------------------------------------------------------
module avr_dec_checker
    import avr_dec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.size_words == 2'd1 || out_data.size_words == 2'd2))
        else $error("bad size");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_res |->
            out_data.size_words == 2'd1 && out_data.target_addr == '0 &&
            out_data.instr_class == '0)
        else $error("invalid item carries fields");

    // an accepted item shows up at the output when nothing stalls
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("item lost");

endmodule

bind avr_instruction_decoder avr_dec_checker u_avr_dec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
